>>> design/csp_pkg.sv
// Shared types and constants for the code/symbol pair bit packer.
// No dependencies; imported by every module of the block.
`default_nettype none

package csp_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 16;
  localparam int PEND_W      = 7;
  localparam int PCNT_W      = 3;
  localparam int WIDTH_W     = 5;
  localparam int TOTAL_W     = 5;
  localparam int ENTRY_BYTES = 3;
  localparam int ACC_W       = PEND_W + CODE_W + BYTE_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_PAIR  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // one unit of work for the back end: up to three finished bytes
  typedef struct packed {
    logic [ENTRY_BYTES*BYTE_W-1:0] bytes;
    logic [1:0]                    nbytes;
  } csp_entry_t;

endpackage

`default_nettype wire

>>> design/csp_front.sv
// Front end: accepts requests, keeps the leftover bits and builds byte entries.
// Depends on csp_pkg.
`default_nettype none

module csp_front #(
  parameter int MAX_CODE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic               req_type,
  input  wire logic [15:0]        code_value,
  input  wire logic [7:0]         symbol_byte,
  input  wire logic [4:0]         code_width,
  output logic                    wr,
  output csp_pkg::csp_entry_t     wr_entry
);
  import csp_pkg::*;

  localparam int CodeLim = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam logic [WIDTH_W-1:0] CODE_LIM = WIDTH_W'(CodeLim);

  logic [PEND_W-1:0]  pending_bits, pending_bits_next;
  logic [PCNT_W-1:0]  pending_count, pending_count_next;

  logic [WIDTH_W-1:0] eff_w;
  logic [CODE_W:0]    mask_ext;
  logic [CODE_W-1:0]  code_m;
  logic [TOTAL_W-1:0] sym_sh;
  logic [ACC_W-1:0]   acc, acc_rest;
  logic [TOTAL_W-1:0] total;
  logic [1:0]         nb;

  always_comb begin
    eff_w    = (code_width > CODE_LIM) ? CODE_LIM : code_width;
    mask_ext = ((CODE_W+1)'(1) << eff_w) - (CODE_W+1)'(1);
    code_m   = code_value & mask_ext[CODE_W-1:0];
    sym_sh   = TOTAL_W'(pending_count) + eff_w;
    acc      = ACC_W'(pending_bits)
             | (ACC_W'(code_m) << pending_count)
             | (ACC_W'(symbol_byte) << sym_sh);
    total    = TOTAL_W'(pending_count) + eff_w + TOTAL_W'(BYTE_W);
    nb       = total[TOTAL_W-1:3];
    acc_rest = acc >> {nb, 3'b000};

    wr                 = 1'b0;
    wr_entry.bytes     = acc[ENTRY_BYTES*BYTE_W-1:0];
    wr_entry.nbytes    = nb;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;

    if (accept) begin
      case (req_type)
        REQ_FLUSH: begin
          // partial byte goes out zero-padded, only if something is held
          wr_entry.bytes  = (ENTRY_BYTES*BYTE_W)'(pending_bits);
          wr_entry.nbytes = 2'd1;
          if (pending_count != '0) begin
            wr                 = 1'b1;
            pending_bits_next  = '0;
            pending_count_next = '0;
          end
        end
        REQ_PAIR: begin
          wr                 = 1'b1;
          pending_bits_next  = acc_rest[PEND_W-1:0];
          pending_count_next = total[PCNT_W-1:0];
        end
        default: begin
          wr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  // a flush with nothing held must not create a beat
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_FLUSH && pending_count == '0) |-> !wr)
    else $error("flush with no pending bits produced an entry");

  // every written entry carries at least one byte
  a_entry_nonzero: assert property (@(posedge clk) disable iff (rst)
    wr |-> (wr_entry.nbytes != 2'd0))
    else $error("empty entry written");

  // unused leftover bits stay clear
  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending_bits >> pending_count) == '0)
    else $error("stray bits above pending count");

endmodule

`default_nettype wire

>>> design/csp_queue.sv
// Short entry queue between the front and back ends.
// Depends on csp_pkg.
`default_nettype none

module csp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire csp_pkg::csp_entry_t wr_entry,
  input  wire logic               rd,
  output csp_pkg::csp_entry_t     rd_entry,
  output logic                    full,
  output logic                    empty
);
  import csp_pkg::*;

  csp_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr + QPTR_W'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd && empty))
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> design/csp_back.sv
// Back end: walks the bytes of each queued entry and drives the result register.
// Depends on csp_pkg.
`default_nettype none

module csp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire csp_pkg::csp_entry_t head,
  output logic                    head_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [7:0]              packed_byte,
  output logic                    last_of_run
);
  import csp_pkg::*;

  logic             out_valid;
  logic [1:0]       idx, idx_next;
  logic             load;
  logic             is_last;
  logic [BYTE_W-1:0] sel_byte;

  assign empty = !out_valid;

  always_comb begin
    load    = head_valid && (!out_valid || pop);
    is_last = (idx == head.nbytes - 2'd1);
    case (idx)
      2'd0:    sel_byte = head.bytes[BYTE_W-1:0];
      2'd1:    sel_byte = head.bytes[2*BYTE_W-1:BYTE_W];
      2'd2:    sel_byte = head.bytes[3*BYTE_W-1:2*BYTE_W];
      default: sel_byte = '0;
    endcase
    head_pop = load && is_last;
    idx_next = idx;
    if (load) begin
      idx_next = is_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      packed_byte <= sel_byte;
      last_of_run <= is_last;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < head.nbytes))
    else $error("byte index beyond entry length");

  a_idx_rests: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (idx == 2'd0))
    else $error("byte index left mid-entry with queue empty");

  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    (load && is_last) |=> (last_of_run && out_valid))
    else $error("final beat of an entry not flagged");

endmodule

`default_nettype wire

>>> design/code_symbol_pair_bit_packer.sv
// Path: an accepted request is written into a queue slot; its bytes then load one at
// a time into the result register. Throughput: one request per cycle into a two-entry
// queue while it is not full; the result register drains one byte per cycle while the
// receiver pops, and a pair yields one to three bytes. Flush with nothing held makes no
// beat. Reset (synchronous) clears the leftover bits, the queue and the result valid
// flag (not the byte payload). Depends on csp_pkg, csp_front, csp_queue and csp_back.
`default_nettype none

module code_symbol_pair_bit_packer #(
  parameter int MAX_CODE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type,
  input  wire logic [15:0] code_value,
  input  wire logic [7:0]  symbol_byte,
  input  wire logic [4:0]  code_width,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       packed_byte,
  output logic             last_of_run
);
  import csp_pkg::*;

  logic       accept;
  logic       q_wr;
  csp_entry_t q_wr_entry;
  csp_entry_t q_head;
  logic       q_pop;
  logic       q_empty;

  assign accept = push && !full;

  csp_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .code_value (code_value),
    .symbol_byte(symbol_byte),
    .code_width (code_width),
    .wr         (q_wr),
    .wr_entry   (q_wr_entry)
  );

  csp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_entry(q_wr_entry),
    .rd      (q_pop),
    .rd_entry(q_head),
    .full    (full),
    .empty   (q_empty)
  );

  csp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head       (q_head),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .packed_byte(packed_byte),
    .last_of_run(last_of_run)
  );

endmodule

`default_nettype wire

>>> dv/csp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the code/symbol pair bit packer: predicts the packed bytes of each
// accepted request and compares them with the bytes popped from the block.
// Depends on csp_pkg.

module csp_checker
  import csp_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        req_type,
  input  logic [15:0] code_value,
  input  logic [7:0]  symbol_byte,
  input  logic [4:0]  code_width,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  packed_byte,
  input  logic        last_of_run,
  output int          fails,
  output int          waiting
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_beat_t;

  localparam int WIDTH_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

  byte_beat_t        expected_bytes[$];
  logic [PEND_W-1:0] held_bits;
  logic [PCNT_W-1:0] held_count;

  task automatic pack_request(input logic rq, input logic [15:0] code,
                              input logic [7:0] sym, input logic [4:0] w_req);
    int             w;
    int             total;
    int             n;
    logic [31:0]    code_m;
    logic [ACC_W-1:0] acc;
    byte_beat_t     b;
    w = (int'(w_req) > WIDTH_CAP) ? WIDTH_CAP : int'(w_req);
    if (rq == REQ_FLUSH) begin
      if (held_count != '0) begin
        b.data = {1'b0, held_bits};
        b.last = 1'b1;
        expected_bytes.push_back(b);
        held_bits  = '0;
        held_count = '0;
      end
    end else begin
      code_m = {16'h0, code} & ((32'h1 << w) - 32'h1);
      acc    = ACC_W'(held_bits);
      acc    = acc | (ACC_W'(code_m) << held_count);
      acc    = acc | (ACC_W'(sym) << (int'(held_count) + w));
      total  = int'(held_count) + w + BYTE_W;
      n      = total / BYTE_W;
      for (int i = 0; i < n; i++) begin
        b.data = acc[BYTE_W-1:0];
        b.last = (i == n - 1);
        expected_bytes.push_back(b);
        acc = acc >> BYTE_W;
      end
      held_bits  = acc[PEND_W-1:0];
      held_count = PCNT_W'(total % BYTE_W);
    end
  endtask

  always @(posedge clk) begin
    byte_beat_t e;
    int         errs;
    errs = 0;
    if (rst) begin
      expected_bytes.delete();
      held_bits  = '0;
      held_count = '0;
      fails      <= 0;
      waiting    <= 0;
    end else begin
      // a byte can never belong to a request taken at the same edge
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, packed_byte, last_of_run);
          errs++;
        end else begin
          e = expected_bytes.pop_front();
          if (packed_byte !== e.data) begin
            $display("%0t: packed_byte expected %02h actual %02h", $time, e.data,
                     packed_byte);
            errs++;
          end
          if (last_of_run !== e.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, e.last,
                     last_of_run);
            errs++;
          end
        end
      end
      if (push && !full)
        pack_request(req_type, code_value, symbol_byte, code_width);
      fails   <= fails + errs;
      waiting <= expected_bytes.size();
    end
  end

endmodule

>>> dv/code_symbol_pair_bit_packer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the code/symbol pair bit packer: drives directed and random
// requests with random idling on both sides and gives the verdict.
// Depends on csp_pkg, csp_checker and the block itself.

module code_symbol_pair_bit_packer_tb;
  import csp_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        req_type = REQ_PAIR;
  logic [15:0] code_value = '0;
  logic [7:0]  symbol_byte = '0;
  logic [4:0]  code_width = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  packed_byte;
  logic        last_of_run;
  int          fails;
  int          waiting;
  int          quiet_cycles = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  code_symbol_pair_bit_packer u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .code_value (code_value),
    .symbol_byte(symbol_byte),
    .code_width (code_width),
    .empty      (empty),
    .pop        (pop),
    .packed_byte(packed_byte),
    .last_of_run(last_of_run)
  );

  csp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .code_value (code_value),
    .symbol_byte(symbol_byte),
    .code_width (code_width),
    .empty      (empty),
    .pop        (pop),
    .packed_byte(packed_byte),
    .last_of_run(last_of_run),
    .fails      (fails),
    .waiting    (waiting)
  );

  // one request beat, preceded by a random gap unless the sender is in a calm stretch
  task automatic send_request(input logic rq, input logic [15:0] code,
                              input logic [7:0] sym, input logic [4:0] w);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    req_type    <= rq;
    code_value  <= code;
    symbol_byte <= sym;
    code_width  <= w;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // receiver: random stalls between byte beats
  initial begin
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic        rq;
    logic [4:0]  w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flush with nothing held, then edge widths and saturation
    send_request(REQ_FLUSH, 16'h0000, 8'h00, 5'd0);
    send_request(REQ_PAIR,  16'hFFFF, 8'hA5, 5'd0);
    send_request(REQ_PAIR,  16'hFFFF, 8'hFF, 5'd16);
    send_request(REQ_PAIR,  16'h007F, 8'h00, 5'd7);
    // seven bits held plus a full-width code gives three bytes
    send_request(REQ_PAIR,  16'hFFFF, 8'hFF, 5'd16);
    send_request(REQ_PAIR,  16'h1234, 8'h5A, 5'd31);
    send_request(REQ_FLUSH, 16'hFFFF, 8'hFF, 5'd31);
    send_request(REQ_FLUSH, 16'h0000, 8'h00, 5'd0);
    send_request(REQ_PAIR,  16'hAAAA, 8'h55, 5'd17);
    send_request(REQ_PAIR,  16'h0001, 8'h80, 5'd1);
    send_request(REQ_PAIR,  16'h0000, 8'h00, 5'd16);
    send_request(REQ_PAIR,  16'hFFF8, 8'hC3, 5'd3);
    send_request(REQ_FLUSH, 16'h5555, 8'hAA, 5'd8);
    send_request(REQ_PAIR,  16'h8000, 8'h01, 5'd16);
    send_request(REQ_PAIR,  16'h001F, 8'hFF, 5'd5);
    send_request(REQ_PAIR,  16'hFFFF, 8'h00, 5'd15);
    send_request(REQ_FLUSH, 16'h0000, 8'h00, 5'd0);
    send_request(REQ_PAIR,  16'h7FFF, 8'h7E, 5'd24);
    send_request(REQ_PAIR,  16'h0F0F, 8'hF0, 5'd12);
    send_request(REQ_FLUSH, 16'h0000, 8'h00, 5'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rq = ($urandom_range(0, 6) == 0) ? REQ_FLUSH : REQ_PAIR;
      case ($urandom_range(0, 7))
        0:       w = 5'd0;
        1:       w = 5'd16;
        2:       w = 5'($urandom_range(17, 31));
        default: w = 5'($urandom_range(1, 15));
      endcase
      send_request(rq, 16'($urandom), 8'($urandom), w);
      if (i == RANDOM_ITEMS / 2) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> code_symbol_pair_bit_packer.f
design/csp_pkg.sv
design/csp_front.sv
design/csp_queue.sv
design/csp_back.sv
design/code_symbol_pair_bit_packer.sv
dv/csp_checker.sv
dv/code_symbol_pair_bit_packer_tb.sv
